// ===== rtl/fcot_pkg.sv =====
// Shared types, widths and constants of the follow camera offset transform.
// Holds the elaboration-time sine/cosine series used to build the trig table.
// No dependencies.
package fcot_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
	localparam int EIGHTH = 1 << (SINE_TABLE_BITS - 3);

	localparam int TRIG_W = 26;
	localparam int ENT_W = 35;
	localparam int TERM_W = 36;
	localparam int ROW_W = 38;

	localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;

	// Reciprocals of the series denominators, scaled by 2^64 and rounded up. Every term
	// that is divided stays below 2^30, so the scaled product gives the exact quotient.
	localparam logic [127:0] TWO_POW_64 = 128'd1 << 64;
	localparam logic [127:0] SIN_RCP [7] = '{
		TWO_POW_64 / 6 + 128'd1, TWO_POW_64 / 20 + 128'd1, TWO_POW_64 / 42 + 128'd1,
		TWO_POW_64 / 72 + 128'd1, TWO_POW_64 / 110 + 128'd1, TWO_POW_64 / 156 + 128'd1,
		TWO_POW_64 / 210 + 128'd1};
	localparam logic [127:0] COS_RCP [7] = '{
		TWO_POW_64 / 2 + 128'd1, TWO_POW_64 / 12 + 128'd1, TWO_POW_64 / 30 + 128'd1,
		TWO_POW_64 / 56 + 128'd1, TWO_POW_64 / 90 + 128'd1, TWO_POW_64 / 132 + 128'd1,
		TWO_POW_64 / 182 + 128'd1};

	localparam logic [7:0] CFG_OFFSET_X = 8'd0;
	localparam logic [7:0] CFG_OFFSET_Y = 8'd1;
	localparam logic [7:0] CFG_OFFSET_Z = 8'd2;
	localparam logic [7:0] CFG_YAW_ANGLE = 8'd3;

	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [ENT_W-1:0] ent_t;
	typedef logic signed [ROW_W-1:0] row_t;
	typedef logic signed [31:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} tgt_t;

	localparam trig_t ONE_Q24 = trig_t'(1 << 24);

	// Sine or cosine of j steps of pi/2^(SINE_TABLE_BITS-1), Q24, for the first octant.
	function automatic trig_t taylor_q24(input int j, input bit cosine);
		longint unsigned step;
		longint unsigned xu;
		longint x;
		longint term;
		longint t2;
		longint sn;
		longint cs;
		longint res;
		logic [127:0] prod;
		step = PI_Q60 >> (SINE_TABLE_BITS - 1);
		xu = (longint'(j) * step) >> 30;
		x = longint'(xu);
		term = x;
		sn = x;
		cs = longint'(1) <<< 30;
		t2 = cs;
		for (int n = 1; n <= 7; n++) begin
			term = (((term * x) >>> 30) * x) >>> 30;
			prod = 128'(term) * SIN_RCP[n-1];
			term = longint'(prod[127:64]);
			t2 = (((t2 * x) >>> 30) * x) >>> 30;
			prod = 128'(t2) * COS_RCP[n-1];
			t2 = longint'(prod[127:64]);
			if ((n & 1) != 0) begin
				sn = sn - term;
				cs = cs - t2;
			end else begin
				sn = sn + term;
				cs = cs + t2;
			end
		end
		res = cosine ? ((cs + 32) >>> 6) : ((sn + 32) >>> 6);
		return res[TRIG_W-1:0];
	endfunction

endpackage

// ===== rtl/fcot_sincos.sv =====
// Sine and cosine of the configured yaw angle, registered.
// Folds the angle into one octant and reads a constant table; uses fcot_pkg.
module fcot_sincos (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          yaw,
	output fcot_pkg::trig_t      sin_q,
	output fcot_pkg::trig_t      cos_q
);

	localparam int QB = fcot_pkg::QUARTER_BITS;
	localparam int TB = fcot_pkg::SINE_TABLE_BITS;
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	fcot_pkg::trig_t sin_tab [fcot_pkg::EIGHTH+1];
	fcot_pkg::trig_t cos_tab [fcot_pkg::EIGHTH+1];

	for (genvar g = 0; g <= fcot_pkg::EIGHTH; g++) begin : g_tab
		assign sin_tab[g] = fcot_pkg::taylor_q24(g, 1'b0);
		assign cos_tab[g] = fcot_pkg::taylor_q24(g, 1'b1);
	end

	logic [TB-1:0] k;
	logic [1:0] quad;
	logic [QB-1:0] r;
	logic low_half;
	logic [QB-1:0] j;
	fcot_pkg::trig_t a, b, s, c, s_n, c_n;

	always_comb begin
		k = yaw[15 -: TB];
		quad = k[TB-1 -: 2];
		r = k[QB-1:0];
		low_half = ({1'b0, r} <= (QB+1)'(fcot_pkg::EIGHTH));
		j = low_half ? r : QB'(((QB+1)'(1) << QB) - {1'b0, r});
		a = sin_tab[j];
		b = cos_tab[j];
		s = low_half ? a : b;
		c = low_half ? b : a;
		case (quad)
			QUAD_0: begin
				s_n = s;
				c_n = c;
			end
			QUAD_1: begin
				s_n = c;
				c_n = -s;
			end
			QUAD_2: begin
				s_n = -s;
				c_n = -c;
			end
			default: begin
				s_n = -c;
				c_n = s;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sin_q <= '0;
			cos_q <= fcot_pkg::ONE_Q24;
		end else begin
			sin_q <= s_n;
			cos_q <= c_n;
		end
	end

endmodule

// ===== rtl/fcot_matrix.sv =====
// Stages 1 and 2: conjugate the quaternion, form its Q30 products, then the
// Q29 rotation matrix entries. Uses fcot_pkg.
module fcot_matrix (
	input  logic                 clk,
	input  logic [1:0]           en,
	input  logic signed [15:0]   quat_x,
	input  logic signed [15:0]   quat_y,
	input  logic signed [15:0]   quat_z,
	input  logic signed [15:0]   quat_w,
	output fcot_pkg::ent_t       m_s2 [9]
);

	logic signed [16:0] x, y, z, w;
	logic signed [33:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	fcot_pkg::ent_t one;

	function automatic fcot_pkg::ent_t ENT_EXT(input logic signed [33:0] v);
		return fcot_pkg::ent_t'(v);
	endfunction

	always_comb begin
		x = -{quat_x[15], quat_x};
		y = -{quat_y[15], quat_y};
		z = -{quat_z[15], quat_z};
		w = {quat_w[15], quat_w};
		one = fcot_pkg::ent_t'(1 << 29);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			xx_s1 <= x * x;
			yy_s1 <= y * y;
			zz_s1 <= z * z;
			xy_s1 <= x * y;
			xz_s1 <= x * z;
			yz_s1 <= y * z;
			wx_s1 <= w * x;
			wy_s1 <= w * y;
			wz_s1 <= w * z;
		end
	end

	// Row-major entries of the rotation matrix.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			m_s2[0] <= one - (ENT_EXT(yy_s1) + ENT_EXT(zz_s1));
			m_s2[1] <= ENT_EXT(xy_s1) - ENT_EXT(wz_s1);
			m_s2[2] <= ENT_EXT(xz_s1) + ENT_EXT(wy_s1);
			m_s2[3] <= ENT_EXT(xy_s1) + ENT_EXT(wz_s1);
			m_s2[4] <= one - (ENT_EXT(xx_s1) + ENT_EXT(zz_s1));
			m_s2[5] <= ENT_EXT(yz_s1) - ENT_EXT(wx_s1);
			m_s2[6] <= ENT_EXT(xz_s1) - ENT_EXT(wy_s1);
			m_s2[7] <= ENT_EXT(yz_s1) + ENT_EXT(wx_s1);
			m_s2[8] <= one - (ENT_EXT(xx_s1) + ENT_EXT(yy_s1));
		end
	end

endmodule

// ===== rtl/fcot_rotate.sv =====
// Stages 3 and 4: multiply the offset by the matrix entries and sum each row,
// rounding every term to Q16.16. Uses fcot_pkg.
module fcot_rotate (
	input  logic                 clk,
	input  logic [1:0]           en,
	input  fcot_pkg::ent_t       m [9],
	input  fcot_pkg::coord_t     off_x,
	input  fcot_pkg::coord_t     off_y,
	input  fcot_pkg::coord_t     off_z,
	output fcot_pkg::row_t       rx_s4,
	output fcot_pkg::row_t       ry_s4,
	output fcot_pkg::row_t       rz_s4
);

	localparam int PW = 32 + fcot_pkg::ENT_W;

	logic signed [PW-1:0] p_s3 [9];
	logic signed [fcot_pkg::TERM_W-1:0] t [9];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_s3[0] <= PW'(off_x) * PW'(m[0]);
			p_s3[1] <= PW'(off_y) * PW'(m[1]);
			p_s3[2] <= PW'(off_z) * PW'(m[2]);
			p_s3[3] <= PW'(off_x) * PW'(m[3]);
			p_s3[4] <= PW'(off_y) * PW'(m[4]);
			p_s3[5] <= PW'(off_z) * PW'(m[5]);
			p_s3[6] <= PW'(off_x) * PW'(m[6]);
			p_s3[7] <= PW'(off_y) * PW'(m[7]);
			p_s3[8] <= PW'(off_z) * PW'(m[8]);
		end
	end

	// Round half up at bit 29: add half an LSB and shift with floor.
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			t[i] = fcot_pkg::TERM_W'((p_s3[i] + (PW'(1) <<< 28)) >>> 29);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			rx_s4 <= fcot_pkg::ROW_W'(t[0]) + fcot_pkg::ROW_W'(t[1]) + fcot_pkg::ROW_W'(t[2]);
			ry_s4 <= fcot_pkg::ROW_W'(t[3]) + fcot_pkg::ROW_W'(t[4]) + fcot_pkg::ROW_W'(t[5]);
			rz_s4 <= fcot_pkg::ROW_W'(t[6]) + fcot_pkg::ROW_W'(t[7]) + fcot_pkg::ROW_W'(t[8]);
		end
	end

endmodule

// ===== rtl/fcot_finish.sv =====
// Stages 5 to 7: yaw turn in the XZ plane, rounding, target add and saturation.
// Uses fcot_pkg.
module fcot_finish (
	input  logic                 clk,
	input  logic [2:0]           en,
	input  fcot_pkg::row_t       rx,
	input  fcot_pkg::row_t       ry,
	input  fcot_pkg::row_t       rz,
	input  fcot_pkg::trig_t      sin_v,
	input  fcot_pkg::trig_t      cos_v,
	input  fcot_pkg::tgt_t       tgt,
	output fcot_pkg::coord_t     camera_x,
	output fcot_pkg::coord_t     camera_y,
	output fcot_pkg::coord_t     camera_z
);

	localparam int MW = fcot_pkg::ROW_W + fcot_pkg::TRIG_W;
	localparam int SW = MW + 1;
	localparam int FW = 42;
	localparam int AW = FW + 2;
	localparam logic signed [AW-1:0] SAT_MAX = AW'(64'sd2147483647);
	localparam logic signed [AW-1:0] SAT_MIN = AW'(-64'sd2147483648);

	logic signed [MW-1:0] xc_s5, zs_s5, xs_s5, zc_s5;
	fcot_pkg::row_t ry_s5, ry_s6;
	logic signed [FW-1:0] fx_s6, fz_s6;
	logic signed [SW-1:0] dx, dz;
	logic signed [AW-1:0] sx, sy, sz;

	function automatic fcot_pkg::coord_t SAT(input logic signed [AW-1:0] v);
		if (v > SAT_MAX) begin
			return SAT_MAX[31:0];
		end else if (v < SAT_MIN) begin
			return SAT_MIN[31:0];
		end
		return v[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en[0]) begin
			xc_s5 <= MW'(rx) * MW'(cos_v);
			zs_s5 <= MW'(rz) * MW'(sin_v);
			xs_s5 <= MW'(rx) * MW'(sin_v);
			zc_s5 <= MW'(rz) * MW'(cos_v);
			ry_s5 <= ry;
		end
	end

	always_comb begin
		dx = SW'(xc_s5) - SW'(zs_s5) + (SW'(1) <<< 23);
		dz = SW'(xs_s5) + SW'(zc_s5) + (SW'(1) <<< 23);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			fx_s6 <= FW'(dx >>> 24);
			fz_s6 <= FW'(dz >>> 24);
			ry_s6 <= ry_s5;
		end
	end

	always_comb begin
		sx = AW'(tgt.x) + AW'(fx_s6);
		sy = AW'(tgt.y) + AW'(ry_s6);
		sz = AW'(tgt.z) + AW'(fz_s6);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			camera_x <= SAT(sx);
			camera_y <= SAT(sy);
			camera_z <= SAT(sz);
		end
	end

endmodule

// ===== rtl/follow_camera_offset_transform_core.sv =====
// Follow camera offset transform, top level: configuration registers, pipeline
// control and the target delay line. Uses fcot_pkg and the fcot_* stage modules.
//
// The block takes one item per clock cycle while the output is not stalled, and
// presents the camera position on its output through a seven-stage
// pipeline: quaternion products, matrix entries, offset-by-entry products, row sums,
// yaw products, rounding, and target add with saturation into
// the output register. Each stage holds its item while the one after it is full
// and stalled, so bubbles close up and nothing is lost or repeated; the input is
// stalled only when every stage holds an item. Sine and cosine of the yaw angle
// come from a constant first-octant table and are registered, so they follow a new
// yaw value in the cycle after the register takes it. The configuration port is always
// ready; registers must be written only while no item is in flight.
module follow_camera_offset_transform_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [7:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [31:0]   target_x,
	input  logic signed [31:0]   target_y,
	input  logic signed [31:0]   target_z,
	input  logic signed [15:0]   quat_x,
	input  logic signed [15:0]   quat_y,
	input  logic signed [15:0]   quat_z,
	input  logic signed [15:0]   quat_w,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   camera_x,
	output logic signed [31:0]   camera_y,
	output logic signed [31:0]   camera_z
);

	// Configuration registers.
	fcot_pkg::coord_t off_x_q, off_y_q, off_z_q;
	logic [15:0] yaw_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
			yaw_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fcot_pkg::CFG_OFFSET_X: off_x_q <= cfg_data;
				fcot_pkg::CFG_OFFSET_Y: off_y_q <= cfg_data;
				fcot_pkg::CFG_OFFSET_Z: off_z_q <= cfg_data;
				fcot_pkg::CFG_YAW_ANGLE: yaw_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Stage valid bits and per-stage load enables. A stage loads when it is empty
	// or when the stage after it loads in the same cycle.
	logic [7:1] v_s;
	logic [8:1] en;

	always_comb begin
		en[8] = !out_stall;
		for (int k = 7; k >= 1; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[1]) begin
				v_s[1] <= in_valid;
			end
			for (int k = 2; k <= 7; k++) begin
				if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
		end
	end

	assign in_stall = !en[1];
	assign out_valid = v_s[7];

	// Target position travels alongside the arithmetic until the final add.
	fcot_pkg::tgt_t tgt_s1, tgt_s2, tgt_s3, tgt_s4, tgt_s5, tgt_s6;

	always_ff @(posedge clk) begin
		if (en[1]) tgt_s1 <= '{x: target_x, y: target_y, z: target_z};
		if (en[2]) tgt_s2 <= tgt_s1;
		if (en[3]) tgt_s3 <= tgt_s2;
		if (en[4]) tgt_s4 <= tgt_s3;
		if (en[5]) tgt_s5 <= tgt_s4;
		if (en[6]) tgt_s6 <= tgt_s5;
	end

	fcot_pkg::trig_t sin_q, cos_q;
	fcot_pkg::ent_t m_s2 [9];
	fcot_pkg::row_t rx_s4, ry_s4, rz_s4;

	fcot_sincos u_sincos (
		.clk    (clk),
		.arst_n (arst_n),
		.yaw    (yaw_q),
		.sin_q  (sin_q),
		.cos_q  (cos_q)
	);

	fcot_matrix u_matrix (
		.clk    (clk),
		.en     (en[2:1]),
		.quat_x (quat_x),
		.quat_y (quat_y),
		.quat_z (quat_z),
		.quat_w (quat_w),
		.m_s2   (m_s2)
	);

	fcot_rotate u_rotate (
		.clk    (clk),
		.en     (en[4:3]),
		.m      (m_s2),
		.off_x  (off_x_q),
		.off_y  (off_y_q),
		.off_z  (off_z_q),
		.rx_s4  (rx_s4),
		.ry_s4  (ry_s4),
		.rz_s4  (rz_s4)
	);

	fcot_finish u_finish (
		.clk      (clk),
		.en       (en[7:5]),
		.rx       (rx_s4),
		.ry       (ry_s4),
		.rz       (rz_s4),
		.sin_v    (sin_q),
		.cos_v    (cos_q),
		.tgt      (tgt_s6),
		.camera_x (camera_x),
		.camera_y (camera_y),
		.camera_z (camera_z)
	);

	// A free output means the whole pipeline moves, so the input is never stalled.
	assert property (@(posedge clk) disable iff (!arst_n) !out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	// A result held by a stalled output is still offered in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	// A zero yaw gives the identity turn.
	assert property (@(posedge clk) disable iff (!arst_n)
		yaw_q == 16'd0 |=> sin_q == '0 && cos_q == fcot_pkg::ONE_Q24)
		else $error("zero yaw is not the identity");

endmodule

// ===== tb/sv/tb_follow_camera_offset_transform_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of follow_camera_offset_transform_core.
// Predicts every camera position in software and compares it with the block's result.
// Depends on fcot_pkg and the RTL of the block.
module tb_follow_camera_offset_transform_core;

	// One input item: target position and orientation quaternion.
	typedef struct {
		logic signed [31:0] tx, ty, tz;
		logic signed [15:0] qx, qy, qz, qw;
	} pose_t;

	// One result item: camera position.
	typedef struct {
		logic signed [31:0] cx, cy, cz;
	} campos_t;

	localparam int DRAIN_CYCLES = 30;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
	logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] camera_x, camera_y, camera_z;

	// Predictor's copy of the configuration registers.
	longint offs_x, offs_y, offs_z;
	int unsigned yaw;

	pose_t pending_poses[$];
	campos_t expected_positions[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;            // no random idling on either side
	bit hold_sender = 1'b0;      // sender pauses until the block drains
	int receiver_hold = 0;       // long receiver hold-off, counted down by the monitor
	int send_gap = 0;
	int recv_gap = 0;

	// Yaw settings of the directed part: zero, fine bits only, quadrant edges, a step just past the first octant, maximum.
	logic [15:0] ang_list[7] = '{16'h0000, 16'h003F, 16'h4000, 16'h8000, 16'hC000,
		16'h2040, 16'hFFFF};

	follow_camera_offset_transform_core i_dut (.*);

	always #2 clk = ~clk;

	// Rounds v by 2^(s-1) and shifts right s with floor; >>> on longint is a floor shift.
	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Sine and cosine of table step k in Q24, by octant folding and a Taylor series.
	function automatic void table_sincos(input int unsigned k, output longint so,
			output longint co);
		int unsigned quarter, eighth, quad, r, j;
		longint unsigned step;
		longint ang, term, t2, sn, cs, a, b, s, c;
		quarter = 1 << (fcot_pkg::SINE_TABLE_BITS - 2);
		eighth = 1 << (fcot_pkg::SINE_TABLE_BITS - 3);
		quad = (k >> (fcot_pkg::SINE_TABLE_BITS - 2)) & 3;
		r = k & (quarter - 1);
		j = (r <= eighth) ? r : quarter - r;
		step = fcot_pkg::PI_Q60 >> (fcot_pkg::SINE_TABLE_BITS - 1);
		ang = longint'((longint'(j) * step) >> 30);
		term = ang;
		sn = ang;
		cs = longint'(1) <<< 30;
		t2 = cs;
		for (int n = 1; n <= 7; n++) begin
			term = (((term * ang) >>> 30) * ang) >>> 30;
			term = term / longint'((2 * n) * (2 * n + 1));
			t2 = (((t2 * ang) >>> 30) * ang) >>> 30;
			t2 = t2 / longint'((2 * n - 1) * (2 * n));
			if (n % 2 == 1) begin
				sn -= term;
				cs -= t2;
			end else begin
				sn += term;
				cs += t2;
			end
		end
		a = round_shift(sn, 6);
		b = round_shift(cs, 6);
		if (r > eighth) begin
			s = b;
			c = a;
		end else begin
			s = a;
			c = b;
		end
		case (quad)
			0: begin so = s; co = c; end
			1: begin so = c; co = -s; end
			2: begin so = -s; co = -c; end
			default: begin so = -c; co = s; end
		endcase
	endfunction

	function automatic longint rotate_row(longint a, longint b, longint c);
		return round_shift(offs_x * a, 29) + round_shift(offs_y * b, 29) +
			round_shift(offs_z * c, 29);
	endfunction

	// Camera position for one pose under the current offset and yaw.
	function automatic campos_t camera_position(pose_t p);
		longint x, y, z, w, xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
		longint rx, ry, rz, s, c, fx, fz;
		campos_t res;
		// The conjugate is taken at 64 bits, so -1.0 turns into an exact +1.0.
		x = -longint'(p.qx);
		y = -longint'(p.qy);
		z = -longint'(p.qz);
		w = longint'(p.qw);
		xx = x * x; yy = y * y; zz = z * z;
		xy = x * y; xz = x * z; yz = y * z;
		wx = w * x; wy = w * y; wz = w * z;
		one = longint'(1) <<< 29;
		rx = rotate_row(one - (yy + zz), xy - wz, xz + wy);
		ry = rotate_row(xy + wz, one - (xx + zz), yz - wx);
		rz = rotate_row(xz - wy, yz + wx, one - (xx + yy));
		table_sincos(yaw >> (16 - fcot_pkg::SINE_TABLE_BITS), s, c);
		fx = round_shift(rx * c - rz * s, 24);
		fz = round_shift(rx * s + rz * c, 24);
		res.cx = 32'(clamp32(longint'(p.tx) + fx));
		res.cy = 32'(clamp32(longint'(p.ty) + ry));
		res.cz = 32'(clamp32(longint'(p.tz) + fz));
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Driver: offers the oldest pending pose, with random bursts of idling.
	always @(posedge clk) begin
		pose_t p;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_positions.push_back(camera_position(pending_poses.pop_front()));
			end
			if (in_valid && in_stall) begin
				// Hold the stalled item unchanged.
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_poses.size() > 0 && !hold_sender &&
					!(in_valid && !in_stall && pending_poses.size() == 0)) begin
				if (!quiet && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(0, 8);
					in_valid <= 1'b0;
				end else begin
					p = pending_poses[0];
					in_valid <= 1'b1;
					target_x <= p.tx; target_y <= p.ty; target_z <= p.tz;
					quat_x <= p.qx; quat_y <= p.qy; quat_z <= p.qz; quat_w <= p.qw;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each result against the oldest expectation and drives stall.
	always @(posedge clk) begin
		campos_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_positions.size() == 0) begin
					report_mismatch("unexpected result", camera_x, '0);
				end else begin
					e = expected_positions.pop_front();
					if (camera_x !== e.cx) report_mismatch("camera_x", camera_x, e.cx);
					if (camera_y !== e.cy) report_mismatch("camera_y", camera_y, e.cy);
					if (camera_z !== e.cz) report_mismatch("camera_z", camera_z, e.cz);
				end
			end
			if (receiver_hold > 0) begin
				receiver_hold <= receiver_hold - 1;
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				recv_gap <= $urandom_range(0, 8);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
			// Watchdog: counts cycles in which neither side accepts an item.
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_follow_camera_offset_transform_core NOT OK");
				$finish;
			end
		end
	end

	function automatic logic signed [15:0] rand_quat();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 32'sh80000000;
			1: return 32'sh7FFFFFFF;
			2: return 32'($urandom_range(0, 2000000)) - 32'sd1000000;
			default: return 32'($urandom);
		endcase
	endfunction

	// Builds a random pose; unit quaternions are common so the rotation path dominates.
	function automatic pose_t rand_pose();
		pose_t p;
		real a, b, c, d, n;
		p.tx = rand_coord(); p.ty = rand_coord(); p.tz = rand_coord();
		if ($urandom_range(0, 3) != 0) begin
			a = real'($urandom_range(0, 2000)) - 1000.0;
			b = real'($urandom_range(0, 2000)) - 1000.0;
			c = real'($urandom_range(0, 2000)) - 1000.0;
			d = real'($urandom_range(0, 2000)) - 1000.0;
			n = $sqrt(a * a + b * b + c * c + d * d) + 1.0e-9;
			p.qx = 16'($rtoi(a / n * 32767.0));
			p.qy = 16'($rtoi(b / n * 32767.0));
			p.qz = 16'($rtoi(c / n * 32767.0));
			p.qw = 16'($rtoi(d / n * 32767.0));
		end else begin
			p.qx = rand_quat(); p.qy = rand_quat(); p.qz = rand_quat(); p.qw = rand_quat();
		end
		return p;
	endfunction

	// Offers one register write over the configuration port and waits until it is taken.
	// The caller drops cfg_valid after its last write.
	task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			fcot_pkg::CFG_OFFSET_X: offs_x = longint'(signed'(val));
			fcot_pkg::CFG_OFFSET_Y: offs_y = longint'(signed'(val));
			fcot_pkg::CFG_OFFSET_Z: offs_z = longint'(signed'(val));
			fcot_pkg::CFG_YAW_ANGLE: yaw = val[15:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [31:0] ox, oy, oz, input logic [15:0] ang);
		write_reg(fcot_pkg::CFG_OFFSET_X, ox);
		write_reg(fcot_pkg::CFG_OFFSET_Y, oy);
		write_reg(fcot_pkg::CFG_OFFSET_Z, oz);
		write_reg(fcot_pkg::CFG_YAW_ANGLE, {16'h0000, ang});
		cfg_valid <= 1'b0;
		// The yaw table output is registered, so let it settle before new items.
		repeat (3) @(posedge clk);
	endtask

	// Waits until every queued pose is accepted and every expected result has arrived.
	task automatic drain();
		while (pending_poses.size() > 0 || in_valid || expected_positions.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		pose_t p;
		logic [15:0] ang;
		offs_x = 0; offs_y = 0; offs_z = 0; yaw = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: reset settings first, then extremes of offsets and quaternions.
		p = '{32'sh00010000, 32'sh80000000, 32'sh7FFFFFFF, 16'sh0, 16'sh0, 16'sh0, 16'sh7FFF};
		pending_poses.push_back(p);
		drain();
		configure(32'h7FFFFFFF, 32'h80000000, 32'h00010000, 16'h0000);
		// Identity-like, negated-most-negative components, and non-unit quaternions.
		pending_poses.push_back('{32'sh0, 32'sh0, 32'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh7FFF});
		pending_poses.push_back('{32'sh0, 32'sh0, 32'sh0, 16'sh8000, 16'sh0, 16'sh0, 16'sh0});
		pending_poses.push_back('{32'sh0, 32'sh0, 32'sh0, 16'sh0, 16'sh8000, 16'sh0, 16'sh0});
		pending_poses.push_back('{32'sh0, 32'sh0, 32'sh0, 16'sh0, 16'sh0, 16'sh8000, 16'sh0});
		pending_poses.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
		pending_poses.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
		pending_poses.push_back('{32'shFFFFFFFF, 32'sh55555555, 32'shAAAAAAAA,
			16'sh5A82, 16'shA57E, 16'sh0000, 16'sh5A82});
		drain();
		// Fine yaw bits below the table resolution, quadrant and octant boundaries and full scale.
		foreach (ang_list[i]) begin
			configure(32'h80000000, 32'h7FFFFFFF, 32'h80000000, ang_list[i]);
			pending_poses.push_back('{32'sh0, 32'sh0, 32'sh0,
				16'sh1234, 16'shEDCB, 16'sh4000, 16'sh6000});
			pending_poses.push_back('{32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000,
				16'sh0, 16'sh0, 16'sh0, 16'sh7FFF});
			drain();
		end

		// Random phases, each with its own settings.
		for (int ph = 0; ph < 8; ph++) begin
			ang = 16'($urandom);
			configure($urandom, $urandom, $urandom, ang);
			if (ph == 2) begin
				// Long receiver hold-off while the sender keeps offering items.
				receiver_hold = 200;
			end
			for (int i = 0; i < 180; i++) begin
				pending_poses.push_back(rand_pose());
				if (ph == 4 && i == 90) begin
					// Sender pauses until everything in flight has come back.
					hold_sender = 1'b1;
					while (in_valid || expected_positions.size() > 0) @(posedge clk);
					hold_sender = 1'b0;
				end
			end
			drain();
		end

		// Last part: no idling on either side, small X and Z offsets for fine rounding.
		quiet = 1'b1;
		configure(32'($urandom_range(0, 200000)) - 32'sd100000, $urandom,
			32'($urandom_range(0, 4000)), 16'($urandom));
		for (int i = 0; i < 200; i++)
			pending_poses.push_back(rand_pose());
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("tb_follow_camera_offset_transform_core OK");
		else
			$display("tb_follow_camera_offset_transform_core NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/fcot_pkg.sv
rtl/fcot_sincos.sv
rtl/fcot_matrix.sv
rtl/fcot_rotate.sv
rtl/fcot_finish.sv
rtl/follow_camera_offset_transform_core.sv
tb/sv/tb_follow_camera_offset_transform_core.sv
